// File: rtl/stmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmh_pkg
// Shared widths, operand codes and the multiply program of the segment versus
// triangle mesh hit core.
// ----------------------------------------------------------------------------
package stmh_pkg;

    localparam int COORD_W    = 16;
    localparam int DIFF_W     = 17;
    localparam int N_W        = 35;   // face normal component
    localparam int L_W        = 54;   // plane distances l1, l2
    localparam int D_W        = 55;   // d = l1 - l2
    localparam int M_W        = 53;   // n x edge component
    localparam int AB_W       = 72;   // edge test partial sums
    localparam int X_W        = 72;   // multiplier wide operand
    localparam int Y_W        = 56;   // multiplier narrow operand
    localparam int P_W        = 128;  // product and edge test value
    localparam int DIG_W      = 8;
    localparam int MUL_DIGITS = Y_W / DIG_W;
    localparam int CNT_W      = 3;
    localparam int PC_W       = 5;
    localparam int TDATA_W    = 9 * COORD_W;
    localparam int CFG_NUM    = 6;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [N_W-1:0]     t_n;
    typedef logic signed [L_W-1:0]     t_l;
    typedef logic signed [D_W-1:0]     t_d;
    typedef logic signed [M_W-1:0]     t_m;
    typedef logic signed [AB_W-1:0]    t_ab;
    typedef logic signed [X_W-1:0]     t_x;
    typedef logic signed [Y_W-1:0]     t_y;
    typedef logic signed [P_W-1:0]     t_prod;

    // wide operand select
    localparam logic [3:0] X_U0 = 4'd0;
    localparam logic [3:0] X_U1 = 4'd1;
    localparam logic [3:0] X_U2 = 4'd2;
    localparam logic [3:0] X_N0 = 4'd3;
    localparam logic [3:0] X_N1 = 4'd4;
    localparam logic [3:0] X_N2 = 4'd5;
    localparam logic [3:0] X_M0 = 4'd6;
    localparam logic [3:0] X_M1 = 4'd7;
    localparam logic [3:0] X_M2 = 4'd8;
    localparam logic [3:0] X_A  = 4'd9;
    localparam logic [3:0] X_B  = 4'd10;

    // narrow operand select
    localparam logic [4:0] Y_V0  = 5'd0;
    localparam logic [4:0] Y_V1  = 5'd1;
    localparam logic [4:0] Y_V2  = 5'd2;
    localparam logic [4:0] Y_SA0 = 5'd3;
    localparam logic [4:0] Y_SA1 = 5'd4;
    localparam logic [4:0] Y_SA2 = 5'd5;
    localparam logic [4:0] Y_EA0 = 5'd6;
    localparam logic [4:0] Y_EA1 = 5'd7;
    localparam logic [4:0] Y_EA2 = 5'd8;
    localparam logic [4:0] Y_E0  = 5'd9;
    localparam logic [4:0] Y_E1  = 5'd10;
    localparam logic [4:0] Y_E2  = 5'd11;
    localparam logic [4:0] Y_SV0 = 5'd12;
    localparam logic [4:0] Y_SV1 = 5'd13;
    localparam logic [4:0] Y_SV2 = 5'd14;
    localparam logic [4:0] Y_ES0 = 5'd15;
    localparam logic [4:0] Y_ES1 = 5'd16;
    localparam logic [4:0] Y_ES2 = 5'd17;
    localparam logic [4:0] Y_D   = 5'd18;
    localparam logic [4:0] Y_L1  = 5'd19;

    // accumulate destination
    localparam logic [3:0] D_N0 = 4'd0;
    localparam logic [3:0] D_N1 = 4'd1;
    localparam logic [3:0] D_N2 = 4'd2;
    localparam logic [3:0] D_L1 = 4'd3;
    localparam logic [3:0] D_L2 = 4'd4;
    localparam logic [3:0] D_M0 = 4'd5;
    localparam logic [3:0] D_M1 = 4'd6;
    localparam logic [3:0] D_M2 = 4'd7;
    localparam logic [3:0] D_A  = 4'd8;
    localparam logic [3:0] D_B  = 4'd9;
    localparam logic [3:0] D_T  = 4'd10;

    // edge being tested: start vertex -> end vertex
    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    localparam logic [PC_W-1:0] PC_L_END = 5'd11;
    localparam logic [PC_W-1:0] PC_EDGE  = 5'd12;
    localparam logic [PC_W-1:0] PC_END   = 5'd25;

    typedef struct packed {
        logic [3:0] src_x;
        logic [4:0] src_y;
        logic [3:0] dst;
        logic       neg;   // subtract the product
        logic       clr;   // start a new sum
    } t_op;

    typedef struct packed {
        logic d_zero;
        logic ratio_ok;
        logic edge_ok;
    } t_stat;

    function automatic t_op f_uop(input logic [PC_W-1:0] pc);
        t_op r;
        case (pc)
            5'd0:  r = '{X_U1, Y_V2,  D_N0, 1'b0, 1'b1};
            5'd1:  r = '{X_U2, Y_V1,  D_N0, 1'b1, 1'b0};
            5'd2:  r = '{X_U2, Y_V0,  D_N1, 1'b0, 1'b1};
            5'd3:  r = '{X_U0, Y_V2,  D_N1, 1'b1, 1'b0};
            5'd4:  r = '{X_U0, Y_V1,  D_N2, 1'b0, 1'b1};
            5'd5:  r = '{X_U1, Y_V0,  D_N2, 1'b1, 1'b0};
            5'd6:  r = '{X_N0, Y_SA0, D_L1, 1'b0, 1'b1};
            5'd7:  r = '{X_N1, Y_SA1, D_L1, 1'b0, 1'b0};
            5'd8:  r = '{X_N2, Y_SA2, D_L1, 1'b0, 1'b0};
            5'd9:  r = '{X_N0, Y_EA0, D_L2, 1'b0, 1'b1};
            5'd10: r = '{X_N1, Y_EA1, D_L2, 1'b0, 1'b0};
            5'd11: r = '{X_N2, Y_EA2, D_L2, 1'b0, 1'b0};
            5'd12: r = '{X_N1, Y_E2,  D_M0, 1'b0, 1'b1};
            5'd13: r = '{X_N2, Y_E1,  D_M0, 1'b1, 1'b0};
            5'd14: r = '{X_N2, Y_E0,  D_M1, 1'b0, 1'b1};
            5'd15: r = '{X_N0, Y_E2,  D_M1, 1'b1, 1'b0};
            5'd16: r = '{X_N0, Y_E1,  D_M2, 1'b0, 1'b1};
            5'd17: r = '{X_N1, Y_E0,  D_M2, 1'b1, 1'b0};
            5'd18: r = '{X_M0, Y_SV0, D_A,  1'b0, 1'b1};
            5'd19: r = '{X_M1, Y_SV1, D_A,  1'b0, 1'b0};
            5'd20: r = '{X_M2, Y_SV2, D_A,  1'b0, 1'b0};
            5'd21: r = '{X_M0, Y_ES0, D_B,  1'b0, 1'b1};
            5'd22: r = '{X_M1, Y_ES1, D_B,  1'b0, 1'b0};
            5'd23: r = '{X_M2, Y_ES2, D_B,  1'b0, 1'b0};
            5'd24: r = '{X_A,  Y_D,   D_T,  1'b0, 1'b1};
            5'd25: r = '{X_B,  Y_L1,  D_T,  1'b0, 1'b0};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/segment_triangle_mesh_hit_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_triangle_mesh_hit_core
// Tests a configured segment against a stream of triangles and reports a
// sticky hit flag at the last triangle of each mesh.
// ----------------------------------------------------------------------------
// Usage:
//   Write the segment start and end points over the APB port (registers 0..5
//   at byte addresses 0x00..0x14: start x, y, z, end x, y, z) while idle.
//   Send triangles on the s_ channel; tdata holds a, b, c vertices, x/y/z
//   each, 16 bits apiece from the low end; tlast marks the mesh's last item.
//   On a last triangle one item leaves on the m_ channel: tdata bit 0 is 1
//   when any triangle of the mesh was crossed, and the flag is cleared.
// Timing:
//   All arithmetic runs through one 72x56 multiplier that takes one 8-bit
//   digit per cycle; a small program sequences the multiply-accumulates.
//   A triangle rejected by the plane or ratio test ends after the normal and
//   the plane distances; one that reaches the edge tests runs 14 more
//   multiplies per edge. s_tready is high only between triangles.
// Reset and stall:
//   Reset clears the registers to zero, the hit flag and the output item.
//   A result waits in the output register while m_tready is low; the next
//   triangle is taken meanwhile and stalls only when its own result is due.
// ----------------------------------------------------------------------------
module segment_triangle_mesh_hit_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // triangle items
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [stmh_pkg::TDATA_W-1:0]  s_tdata,  // tri_a_x, tri_a_y, tri_a_z, tri_b_x,
                                                    // tri_b_y, tri_b_z, tri_c_x, tri_c_y,
                                                    // tri_c_z
    input  logic                          s_tlast,  // last_triangle
    // hit items
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,  // hit, zero fill
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MSTART = 3'd1;
    localparam logic [2:0] S_MWAIT  = 3'd2;
    localparam logic [2:0] S_DCALC  = 3'd3;
    localparam logic [2:0] S_RATIO  = 3'd4;
    localparam logic [2:0] S_ECHK   = 3'd5;
    localparam logic [2:0] S_FIN    = 3'd6;

    logic [2:0]                    r_state;
    logic [stmh_pkg::PC_W-1:0]     r_pc;
    logic [1:0]                    r_edge;
    logic                          r_last;
    logic                          r_hit;
    logic                          r_ovalid;
    logic                          r_ohit;
    stmh_pkg::t_coord              r_cfg [stmh_pkg::CFG_NUM];
    stmh_pkg::t_coord              w_seg_s [3];
    stmh_pkg::t_coord              w_seg_e [3];

    stmh_pkg::t_op                 w_op;
    stmh_pkg::t_stat               w_stat;
    stmh_pkg::t_x                  w_x;
    stmh_pkg::t_y                  w_y;
    logic                          w_done;
    logic [stmh_pkg::P_W-1:0]      w_prod;
    logic                          w_prod_neg;
    logic [stmh_pkg::CFG_IDX_W-1:0] w_cidx;
    logic                          w_cfg_wr;

    assign w_op     = stmh_pkg::f_uop(r_pc);
    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_ovalid;
    assign m_tdata  = {7'b0, r_ohit};

    for (genvar k = 0; k < 3; k++) begin : g_seg
        assign w_seg_s[k] = r_cfg[k];
        assign w_seg_e[k] = r_cfg[3+k];
    end

    stmh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_MSTART),
        .i_x     (w_x),
        .i_y     (w_y),
        .o_done  (w_done),
        .o_prod  (w_prod),
        .o_neg   (w_prod_neg)
    );

    stmh_dp u_dp (
        .i_clk      (i_clk),
        .i_load     (s_tvalid && s_tready),
        .i_tdata    (s_tdata),
        .i_seg_s    (w_seg_s),
        .i_seg_e    (w_seg_e),
        .i_op       (w_op),
        .i_edge     (r_edge),
        .i_dcalc    (r_state == S_DCALC),
        .i_wr       ((r_state == S_MWAIT) && w_done),
        .i_prod     (w_prod),
        .i_prod_neg (w_prod_neg),
        .o_x        (w_x),
        .o_y        (w_y),
        .o_stat     (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pc     <= '0;
            r_edge   <= stmh_pkg::EDGE_AB;
            r_last   <= 1'b0;
            r_hit    <= 1'b0;
            r_ovalid <= 1'b0;
            r_ohit   <= 1'b0;
        end else begin
            if (r_ovalid && m_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        r_last  <= s_tlast;
                        r_pc    <= '0;
                        r_state <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    r_state <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (w_done) begin
                        r_pc <= r_pc + 1'b1;
                        if (r_pc == stmh_pkg::PC_L_END) begin
                            r_state <= S_DCALC;
                        end else if (r_pc == stmh_pkg::PC_END) begin
                            r_state <= S_ECHK;
                        end else begin
                            r_state <= S_MSTART;
                        end
                    end
                end
                S_DCALC: begin
                    r_state <= S_RATIO;
                end
                S_RATIO: begin
                    // drop parallel or degenerate triangles and misses of the span
                    if (w_stat.d_zero || !w_stat.ratio_ok) begin
                        r_state <= S_FIN;
                    end else begin
                        r_edge  <= stmh_pkg::EDGE_AB;
                        r_pc    <= stmh_pkg::PC_EDGE;
                        r_state <= S_MSTART;
                    end
                end
                S_ECHK: begin
                    if (!w_stat.edge_ok) begin
                        r_state <= S_FIN;
                    end else if (r_edge == stmh_pkg::EDGE_CA) begin
                        r_hit   <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_edge  <= r_edge + 1'b1;
                        r_pc    <= stmh_pkg::PC_EDGE;
                        r_state <= S_MSTART;
                    end
                end
                S_FIN: begin
                    if (!r_last) begin
                        r_state <= S_IDLE;
                    end else if (!r_ovalid || m_tready) begin
                        r_ovalid <= 1'b1;
                        r_ohit   <= r_hit;
                        r_hit    <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    assign pready   = 1'b1;
    assign w_cidx   = paddr[4:2];
    assign w_cfg_wr = psel && penable && pwrite
                   && (w_cidx < stmh_pkg::CFG_IDX_W'(stmh_pkg::CFG_NUM));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < stmh_pkg::CFG_NUM; k++) begin
                r_cfg[k] <= '0;
            end
        end else if (w_cfg_wr) begin
            r_cfg[w_cidx] <= pwdata[stmh_pkg::COORD_W-1:0];
        end
    end

    always_comb begin
        if (w_cidx < stmh_pkg::CFG_IDX_W'(stmh_pkg::CFG_NUM)) begin
            prdata = {16'b0, r_cfg[w_cidx]};
        end else begin
            prdata = '0;
        end
    end

endmodule

// File: rtl/stmh_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmh_mul
// Shared signed multiplier: 72-bit by 56-bit, one 8-bit digit of the narrow
// operand's magnitude per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module stmh_mul (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  stmh_pkg::t_x                   i_x,
    input  stmh_pkg::t_y                   i_y,
    output logic                           o_done,
    output logic [stmh_pkg::P_W-1:0]       o_prod,
    output logic                           o_neg
);

    logic [stmh_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_done;
    stmh_pkg::t_x                r_x;
    logic [stmh_pkg::Y_W-1:0]    r_mag;
    logic                        r_neg;
    logic [stmh_pkg::P_W-1:0]    r_p;
    logic signed [stmh_pkg::X_W+stmh_pkg::DIG_W:0] w_pp;

    assign w_pp = r_x * $signed({1'b0, r_mag[stmh_pkg::Y_W-1 -: stmh_pkg::DIG_W]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= stmh_pkg::CNT_W'(stmh_pkg::MUL_DIGITS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_neg <= i_y[stmh_pkg::Y_W-1];
            r_mag <= i_y[stmh_pkg::Y_W-1] ? $unsigned(~i_y + 1'b1) : $unsigned(i_y);
            r_p   <= '0;
        end else if (r_cnt != '0) begin
            r_p   <= (r_p << stmh_pkg::DIG_W)
                   + {{(stmh_pkg::P_W-stmh_pkg::X_W-stmh_pkg::DIG_W-1){w_pp[stmh_pkg::X_W+stmh_pkg::DIG_W]}},
                      w_pp};
            r_mag <= r_mag << stmh_pkg::DIG_W;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;
    assign o_neg  = r_neg;

endmodule

// File: rtl/stmh_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stmh_dp
// Triangle datapath: vertex registers, operand select for the shared
// multiplier, accumulate write-back and the ratio and edge side tests.
// ----------------------------------------------------------------------------
module stmh_dp (
    input  logic                             i_clk,
    input  logic                             i_load,
    input  logic [stmh_pkg::TDATA_W-1:0]     i_tdata,
    input  stmh_pkg::t_coord                 i_seg_s [3],
    input  stmh_pkg::t_coord                 i_seg_e [3],
    input  stmh_pkg::t_op                    i_op,
    input  logic [1:0]                       i_edge,
    input  logic                             i_dcalc,
    input  logic                             i_wr,
    input  logic [stmh_pkg::P_W-1:0]         i_prod,
    input  logic                             i_prod_neg,
    output stmh_pkg::t_x                     o_x,
    output stmh_pkg::t_y                     o_y,
    output stmh_pkg::t_stat                  o_stat
);

    stmh_pkg::t_coord r_a [3];
    stmh_pkg::t_coord r_b [3];
    stmh_pkg::t_coord r_c [3];
    stmh_pkg::t_n     r_n [3];
    stmh_pkg::t_m     r_m [3];
    stmh_pkg::t_l     r_l1;
    stmh_pkg::t_l     r_l2;
    stmh_pkg::t_d     r_d;
    stmh_pkg::t_ab    r_acc_a;
    stmh_pkg::t_ab    r_acc_b;
    stmh_pkg::t_prod  r_t;

    stmh_pkg::t_coord w_v [3];
    stmh_pkg::t_coord w_w [3];
    stmh_pkg::t_diff  w_u [3];
    stmh_pkg::t_diff  w_vv [3];
    stmh_pkg::t_diff  w_sa [3];
    stmh_pkg::t_diff  w_ea [3];
    stmh_pkg::t_diff  w_e [3];
    stmh_pkg::t_diff  w_sv [3];
    stmh_pkg::t_diff  w_es [3];
    stmh_pkg::t_prod  w_old;
    stmh_pkg::t_prod  w_sum;
    stmh_pkg::t_d     w_l1x;
    logic             w_neg;

    always_comb begin
        case (i_edge)
            stmh_pkg::EDGE_AB: begin
                w_v = r_a;
                w_w = r_b;
            end
            stmh_pkg::EDGE_BC: begin
                w_v = r_b;
                w_w = r_c;
            end
            default: begin
                w_v = r_c;
                w_w = r_a;
            end
        endcase
    end

    for (genvar k = 0; k < 3; k++) begin : g_diff
        assign w_u[k]  = stmh_pkg::t_diff'(r_b[k]) - stmh_pkg::t_diff'(r_a[k]);
        assign w_vv[k] = stmh_pkg::t_diff'(r_c[k]) - stmh_pkg::t_diff'(r_a[k]);
        assign w_sa[k] = stmh_pkg::t_diff'(i_seg_s[k]) - stmh_pkg::t_diff'(r_a[k]);
        assign w_ea[k] = stmh_pkg::t_diff'(i_seg_e[k]) - stmh_pkg::t_diff'(r_a[k]);
        assign w_e[k]  = stmh_pkg::t_diff'(w_w[k]) - stmh_pkg::t_diff'(w_v[k]);
        assign w_sv[k] = stmh_pkg::t_diff'(i_seg_s[k]) - stmh_pkg::t_diff'(w_v[k]);
        assign w_es[k] = stmh_pkg::t_diff'(i_seg_e[k]) - stmh_pkg::t_diff'(i_seg_s[k]);
    end

    always_comb begin
        case (i_op.src_x)
            stmh_pkg::X_U0: o_x = stmh_pkg::t_x'(w_u[0]);
            stmh_pkg::X_U1: o_x = stmh_pkg::t_x'(w_u[1]);
            stmh_pkg::X_U2: o_x = stmh_pkg::t_x'(w_u[2]);
            stmh_pkg::X_N0: o_x = stmh_pkg::t_x'(r_n[0]);
            stmh_pkg::X_N1: o_x = stmh_pkg::t_x'(r_n[1]);
            stmh_pkg::X_N2: o_x = stmh_pkg::t_x'(r_n[2]);
            stmh_pkg::X_M0: o_x = stmh_pkg::t_x'(r_m[0]);
            stmh_pkg::X_M1: o_x = stmh_pkg::t_x'(r_m[1]);
            stmh_pkg::X_M2: o_x = stmh_pkg::t_x'(r_m[2]);
            stmh_pkg::X_A:  o_x = r_acc_a;
            stmh_pkg::X_B:  o_x = r_acc_b;
            default:        o_x = '0;
        endcase
    end

    always_comb begin
        case (i_op.src_y)
            stmh_pkg::Y_V0:  o_y = stmh_pkg::t_y'(w_vv[0]);
            stmh_pkg::Y_V1:  o_y = stmh_pkg::t_y'(w_vv[1]);
            stmh_pkg::Y_V2:  o_y = stmh_pkg::t_y'(w_vv[2]);
            stmh_pkg::Y_SA0: o_y = stmh_pkg::t_y'(w_sa[0]);
            stmh_pkg::Y_SA1: o_y = stmh_pkg::t_y'(w_sa[1]);
            stmh_pkg::Y_SA2: o_y = stmh_pkg::t_y'(w_sa[2]);
            stmh_pkg::Y_EA0: o_y = stmh_pkg::t_y'(w_ea[0]);
            stmh_pkg::Y_EA1: o_y = stmh_pkg::t_y'(w_ea[1]);
            stmh_pkg::Y_EA2: o_y = stmh_pkg::t_y'(w_ea[2]);
            stmh_pkg::Y_E0:  o_y = stmh_pkg::t_y'(w_e[0]);
            stmh_pkg::Y_E1:  o_y = stmh_pkg::t_y'(w_e[1]);
            stmh_pkg::Y_E2:  o_y = stmh_pkg::t_y'(w_e[2]);
            stmh_pkg::Y_SV0: o_y = stmh_pkg::t_y'(w_sv[0]);
            stmh_pkg::Y_SV1: o_y = stmh_pkg::t_y'(w_sv[1]);
            stmh_pkg::Y_SV2: o_y = stmh_pkg::t_y'(w_sv[2]);
            stmh_pkg::Y_ES0: o_y = stmh_pkg::t_y'(w_es[0]);
            stmh_pkg::Y_ES1: o_y = stmh_pkg::t_y'(w_es[1]);
            stmh_pkg::Y_ES2: o_y = stmh_pkg::t_y'(w_es[2]);
            stmh_pkg::Y_D:   o_y = stmh_pkg::t_y'(r_d);
            stmh_pkg::Y_L1:  o_y = stmh_pkg::t_y'(r_l1);
            default:         o_y = '0;
        endcase
    end

    always_comb begin
        case (i_op.dst)
            stmh_pkg::D_N0: w_old = stmh_pkg::t_prod'(r_n[0]);
            stmh_pkg::D_N1: w_old = stmh_pkg::t_prod'(r_n[1]);
            stmh_pkg::D_N2: w_old = stmh_pkg::t_prod'(r_n[2]);
            stmh_pkg::D_L1: w_old = stmh_pkg::t_prod'(r_l1);
            stmh_pkg::D_L2: w_old = stmh_pkg::t_prod'(r_l2);
            stmh_pkg::D_M0: w_old = stmh_pkg::t_prod'(r_m[0]);
            stmh_pkg::D_M1: w_old = stmh_pkg::t_prod'(r_m[1]);
            stmh_pkg::D_M2: w_old = stmh_pkg::t_prod'(r_m[2]);
            stmh_pkg::D_A:  w_old = stmh_pkg::t_prod'(r_acc_a);
            stmh_pkg::D_B:  w_old = stmh_pkg::t_prod'(r_acc_b);
            stmh_pkg::D_T:  w_old = r_t;
            default:        w_old = '0;
        endcase
        if (i_op.clr) begin
            w_old = '0;
        end
    end

    // negate the magnitude product when exactly one of the signs asks for it
    assign w_neg = i_op.neg ^ i_prod_neg;
    assign w_sum = w_old + $signed(i_prod ^ {stmh_pkg::P_W{w_neg}})
                 + $signed({{(stmh_pkg::P_W-1){1'b0}}, w_neg});

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            for (int k = 0; k < 3; k++) begin
                r_a[k] <= i_tdata[k*stmh_pkg::COORD_W +: stmh_pkg::COORD_W];
                r_b[k] <= i_tdata[(3+k)*stmh_pkg::COORD_W +: stmh_pkg::COORD_W];
                r_c[k] <= i_tdata[(6+k)*stmh_pkg::COORD_W +: stmh_pkg::COORD_W];
            end
        end
        if (i_dcalc) begin
            r_d <= stmh_pkg::t_d'(r_l1) - stmh_pkg::t_d'(r_l2);
        end
        if (i_wr) begin
            case (i_op.dst)
                stmh_pkg::D_N0: r_n[0]  <= w_sum[stmh_pkg::N_W-1:0];
                stmh_pkg::D_N1: r_n[1]  <= w_sum[stmh_pkg::N_W-1:0];
                stmh_pkg::D_N2: r_n[2]  <= w_sum[stmh_pkg::N_W-1:0];
                stmh_pkg::D_L1: r_l1    <= w_sum[stmh_pkg::L_W-1:0];
                stmh_pkg::D_L2: r_l2    <= w_sum[stmh_pkg::L_W-1:0];
                stmh_pkg::D_M0: r_m[0]  <= w_sum[stmh_pkg::M_W-1:0];
                stmh_pkg::D_M1: r_m[1]  <= w_sum[stmh_pkg::M_W-1:0];
                stmh_pkg::D_M2: r_m[2]  <= w_sum[stmh_pkg::M_W-1:0];
                stmh_pkg::D_A:  r_acc_a <= w_sum[stmh_pkg::AB_W-1:0];
                stmh_pkg::D_B:  r_acc_b <= w_sum[stmh_pkg::AB_W-1:0];
                stmh_pkg::D_T:  r_t     <= w_sum;
                default: ;
            endcase
        end
    end

    // ratio test: l1 must lie between 0 and d, endpoints included
    assign w_l1x = stmh_pkg::t_d'(r_l1);

    always_comb begin
        o_stat.d_zero = (r_d == '0);
        if (!r_d[stmh_pkg::D_W-1]) begin
            o_stat.ratio_ok = !w_l1x[stmh_pkg::D_W-1] && !(w_l1x > r_d);
            o_stat.edge_ok  = !r_t[stmh_pkg::P_W-1];
        end else begin
            o_stat.ratio_ok = (w_l1x[stmh_pkg::D_W-1] || (w_l1x == '0)) && !(w_l1x < r_d);
            o_stat.edge_ok  = r_t[stmh_pkg::P_W-1] || (r_t == '0);
        end
    end

endmodule
